@@ hdl/tcgr_pkg.sv @@
`timescale 1ns / 1ps

package tcgr_pkg;

	localparam int COORD_W = 13;
	localparam int Y_W     = 16;
	localparam int ADDR_W  = 24;
	localparam int COLOR_W = 32;
	localparam int MASK_W  = 8;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	localparam int CELL_W = 8;
	localparam int CELL_H = 16;
	localparam int CNT_W  = $clog2(CELL_H);
	localparam logic [Y_W-1:0] Y_MAX = '1;

	localparam logic [2:0] ACT_LOAD   = 3'd0;
	localparam logic [2:0] ACT_PRINT  = 3'd1;
	localparam logic [2:0] ACT_NEWL   = 3'd2;
	localparam logic [2:0] ACT_BACKSP = 3'd3;
	localparam logic [2:0] ACT_CENTER = 3'd4;

	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_STRIDE        = 3'd2;
	localparam logic [2:0] REG_FG_COLOR      = 3'd3;
	localparam logic [2:0] REG_BG_COLOR      = 3'd4;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
	localparam logic [COORD_W-1:0] STRIDE_RST        = 13'd640;
	localparam logic [COLOR_W-1:0] FG_COLOR_RST      = 32'h00FF_FFFF;
	localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 32'h0000_0000;

endpackage

@@ hdl/text_console_glyph_renderer.sv @@
`timescale 1ns / 1ps

// Text console renderer with a bitmap font store and a text cursor.
// Input channel (in_valid / in_stall): one beat carries one action. Loading a
// font row, newline, center and unknown actions take effect in the cycle the
// beat is accepted and produce nothing on the output channel.
// Print and backspace each produce a burst of row writes on the output channel
// (out_valid / out_stall): GLYPH_ROWS rows for print, sixteen for backspace,
// with last set on the final beat. After the input beat is accepted, the
// block passes through an address setup state into the row state, which
// registers one row write a cycle into the output register while the
// receiver does not stall. in_stall is high in the address setup and row
// states. The row rate is set by the single font memory read port and the
// address adder, which steps the framebuffer address by the stride register
// each row after one multiply for the first row.
// A stall on the output freezes the burst; the final row may still wait in
// the output register while the next input beat is already taken.
// Reset clears the cursor to the top left corner and loads the register
// defaults; the font store holds nothing meaningful until rows are loaded.
// The user must write APB registers only while idle; the block does not check.
module text_console_glyph_renderer #(
	parameter int GLYPH_ROWS  = 16,
	parameter int GLYPH_COUNT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcgr_pkg::APB_AW-1:0]     paddr,
	input  logic [tcgr_pkg::APB_DW-1:0]     pwdata,
	output logic [tcgr_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      action,
	input  logic [7:0]                      char_code,
	input  logic [3:0]                      glyph_row,
	input  logic [7:0]                      glyph_bits,
	input  logic                            use_default_color,
	input  logic [tcgr_pkg::COLOR_W-1:0]    draw_color,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcgr_pkg::ADDR_W-1:0]     word_address,
	output logic [tcgr_pkg::MASK_W-1:0]     row_mask,
	output logic [tcgr_pkg::COLOR_W-1:0]    pixel_color,
	output logic                            out_of_frame,
	output logic                            last
);
	import tcgr_pkg::*;

	localparam int STORE = GLYPH_COUNT * GLYPH_ROWS;
	localparam int AW    = $clog2(STORE);
	localparam int CW    = $clog2(256 * GLYPH_ROWS);
	localparam int IW    = (AW > CW) ? AW : CW;
	localparam int ROW_W = Y_W + 1;
	localparam int PROD_W = ROW_W + COORD_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_ROW  = 3'b100
	} state_t;

	function automatic logic [Y_W-1:0] y_down(input logic [Y_W-1:0] y);
		logic [Y_W:0] n;
		n = {1'b0, y} + (Y_W+1)'(CELL_H);
		return n[Y_W] ? Y_MAX : n[Y_W-1:0];
	endfunction

	function automatic logic [Y_W-1:0] y_up(input logic [Y_W-1:0] y);
		return (y >= Y_W'(CELL_H)) ? y - Y_W'(CELL_H) : '0;
	endfunction

	// Configuration registers.
	logic [COORD_W-1:0] width_q, height_q, stride_q;
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
			stride_q <= STRIDE_RST;
			fg_q     <= FG_COLOR_RST;
			bg_q     <= BG_COLOR_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SCREEN_WIDTH:  width_q  <= pwdata[COORD_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[COORD_W-1:0];
				REG_STRIDE:        stride_q <= pwdata[COORD_W-1:0];
				REG_FG_COLOR:      fg_q     <= pwdata;
				REG_BG_COLOR:      bg_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SCREEN_WIDTH:  prdata = APB_DW'(width_q);
			REG_SCREEN_HEIGHT: prdata = APB_DW'(height_q);
			REG_STRIDE:        prdata = APB_DW'(stride_q);
			REG_FG_COLOR:      prdata = fg_q;
			REG_BG_COLOR:      prdata = bg_q;
			default:           prdata = '0;
		endcase
	end

	// Sequencer and cursor.
	state_t             state_q;
	logic [COORD_W-1:0] cx_q;
	logic [Y_W-1:0]     cy_q;
	logic [CNT_W-1:0]   cnt_q, last_cnt_q, cnt_next;
	logic [IW-1:0]      base_q, rd_idx, wr_idx;
	logic [ROW_W-1:0]   row_q;
	logic [COORD_W-1:0] col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [MASK_W-1:0]  bs_mask_q, rdata_q, mask_now;
	logic [COLOR_W-1:0] color_q;
	logic               is_print_q, code_ok_q;
	logic               in_fire, slot_free, row_fire;
	logic               code_ok, load_ok;

	logic [PROD_W-1:0]  base_prod;

	logic [COORD_W:0]   pr_x;
	logic               pr_wrap;
	logic [COORD_W-1:0] bs_x0, bs_col;
	logic [Y_W-1:0]     bs_y0;
	logic               bs_wide;
	logic [MASK_W-1:0]  bs_mask;

	logic [MASK_W-1:0]  font_mem [STORE];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;
	assign row_fire  = (state_q == ST_ROW) && slot_free;

	assign code_ok = 32'(char_code) < GLYPH_COUNT;
	assign load_ok = code_ok && (32'(glyph_row) < GLYPH_ROWS);
	assign wr_idx  = IW'(char_code) * IW'(GLYPH_ROWS) + IW'(glyph_row);

	// Print: advance by one cell, wrap when the next cell would not fit.
	assign pr_x    = {1'b0, cx_q} + (COORD_W+1)'(CELL_W);
	assign pr_wrap = ({1'b0, pr_x} + (COORD_W+2)'(CELL_W)) > (COORD_W+2)'(width_q);

	// Backspace: at line start, first jump to the end of the line above.
	assign bs_x0   = (cx_q == '0) ? width_q : cx_q;
	assign bs_y0   = (cx_q == '0) ? y_up(cy_q) : cy_q;
	assign bs_wide = bs_x0 >= COORD_W'(CELL_W);
	assign bs_col  = bs_wide ? bs_x0 - COORD_W'(CELL_W) : '0;
	assign bs_mask = bs_wide ? '1 : ~(8'hFF << bs_x0[2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cx_q    <= '0;
			cy_q    <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						case (action)
							ACT_PRINT: begin
								state_q <= ST_MUL;
								cx_q    <= pr_wrap ? '0 : pr_x[COORD_W-1:0];
								cy_q    <= pr_wrap ? y_down(cy_q) : cy_q;
							end
							ACT_NEWL: begin
								cx_q <= '0;
								cy_q <= y_down(cy_q);
							end
							ACT_BACKSP: begin
								state_q <= ST_MUL;
								cx_q    <= bs_wide ? bs_col : width_q;
								cy_q    <= bs_wide ? bs_y0 : y_up(bs_y0);
							end
							ACT_CENTER: begin
								cx_q <= stride_q >> 1;
								cy_q <= Y_W'(height_q >> 1);
							end
							default: ;
						endcase
					end
				end
				ST_MUL: state_q <= ST_ROW;
				ST_ROW: begin
					if (row_fire) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == last_cnt_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item context captured at accept.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_print_q <= (action == ACT_PRINT);
			code_ok_q  <= code_ok;
			base_q     <= IW'(char_code) * IW'(GLYPH_ROWS);
			bs_mask_q  <= bs_mask;
			if (action == ACT_PRINT) begin
				row_q      <= {1'b0, cy_q};
				col_q      <= cx_q;
				color_q    <= use_default_color ? fg_q : draw_color;
				last_cnt_q <= CNT_W'(GLYPH_ROWS - 1);
			end else begin
				row_q      <= {1'b0, bs_y0};
				col_q      <= bs_col;
				color_q    <= bg_q;
				last_cnt_q <= CNT_W'(CELL_H - 1);
			end
		end else if (row_fire) begin
			row_q <= row_q + 1'b1;
		end
	end

	// One multiply for the first row, then the address adder steps by stride.
	assign base_prod = PROD_W'(row_q) * PROD_W'(stride_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			addr_q <= base_prod[ADDR_W-1:0] + ADDR_W'(col_q);
		end else if (row_fire) begin
			addr_q <= addr_q + ADDR_W'(stride_q);
		end
	end

	// Font store. The read address follows the next row count, so the
	// registered data always belongs to the row now in cnt_q.
	assign cnt_next = row_fire ? cnt_q + 1'b1 : cnt_q;
	assign rd_idx   = base_q + IW'(cnt_next);

	always_ff @(posedge clk) begin
		if (in_fire && (action == ACT_LOAD) && load_ok) begin
			font_mem[wr_idx[AW-1:0]] <= glyph_bits;
		end
		rdata_q <= font_mem[rd_idx[AW-1:0]];
	end

	assign mask_now = is_print_q ? (code_ok_q ? rdata_q : '0) : bs_mask_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (row_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (row_fire) begin
			word_address <= addr_q;
			row_mask     <= mask_now;
			pixel_color  <= color_q;
			out_of_frame <= row_q >= ROW_W'(height_q);
			last         <= (cnt_q == last_cnt_q);
		end
	end

	// Between items, a waiting beat can only be the last one of a burst.
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!out_valid || last))
		else $error("non-final row write pending while idle");

	a_rise_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_ROW))
		else $error("row write appeared outside the row phase");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW) |-> (cnt_q <= last_cnt_q))
		else $error("row counter ran past the burst length");

	a_mul_then_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_ROW && cnt_q == '0))
		else $error("address setup not followed by the first row");

endmodule
